### hdl/sha256_byte_stream_hasher_unit_defines.svh
// Assertion macros used by the checker file.
`ifndef SHA256_BYTE_STREAM_HASHER_UNIT_DEFINES_SVH
`define SHA256_BYTE_STREAM_HASHER_UNIT_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define SHA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication whose consequent is checked in the cycle after the condition.
`define SHA_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

### hdl/sha_pkg.sv
package sha_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       final_req;
    } in_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } out_item_t;

    // Controls from the sequencer to the round datapath.
    typedef struct packed {
        logic       load_init;   // restart the chaining words
        logic       start;       // copy chaining words into working vars
        logic       round;       // run one round
        logic [5:0] round_idx;
        logic       finish;      // add working vars into chaining words
        logic       shift_out;   // rotate chaining words for output
    } core_ctl_t;

    localparam logic [255:0] INIT_H = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] k;
        case (idx)
            6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
            6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
            6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
            default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

endpackage

### hdl/sha_sched.sv
// Message schedule: 16-word sliding window, shifted once per round.
module sha_sched (
    input  logic        clk,
    input  logic        load,      // shift a byte into the window
    input  logic [7:0]  byte_in,
    input  logic        step,      // advance one round
    output logic [31:0] w
);
    logic [31:0] win_reg [16];
    logic [31:0] s0, s1, w_new;

    assign w  = win_reg[0];
    assign s0 = {win_reg[1][6:0], win_reg[1][31:7]} ^ {win_reg[1][17:0], win_reg[1][31:18]}
              ^ (win_reg[1] >> 3);
    assign s1 = {win_reg[14][16:0], win_reg[14][31:17]}
              ^ {win_reg[14][18:0], win_reg[14][31:19]} ^ (win_reg[14] >> 10);
    assign w_new = s1 + win_reg[9] + s0 + win_reg[0];

    // Bytes enter at the low end of word 15 and move toward word 0.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int i = 0; i < 15; i++)
            begin
                win_reg[i] <= {win_reg[i][23:0], win_reg[i + 1][31:24]};
            end
            win_reg[15] <= {win_reg[15][23:0], byte_in};
        end
        else if (step)
        begin
            for (int i = 0; i < 15; i++)
            begin
                win_reg[i] <= win_reg[i + 1];
            end
            win_reg[15] <= w_new;
        end
    end
endmodule

### hdl/sha_core.sv
// Round unit and chaining words.
module sha_core (
    input  logic             clk,
    input  logic             rst_n,
    input  sha_pkg::core_ctl_t ctl,
    input  logic [31:0]      w,
    output logic [31:0]      h0
);
    logic [31:0] h_reg [8];
    logic [31:0] v_reg [8];
    logic [31:0] big0, big1, ch, maj, t1, t2;

    assign h0   = h_reg[0];
    assign big1 = {v_reg[4][5:0], v_reg[4][31:6]} ^ {v_reg[4][10:0], v_reg[4][31:11]}
                ^ {v_reg[4][24:0], v_reg[4][31:25]};
    assign ch   = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
    assign big0 = {v_reg[0][1:0], v_reg[0][31:2]} ^ {v_reg[0][12:0], v_reg[0][31:13]}
                ^ {v_reg[0][21:0], v_reg[0][31:22]};
    assign maj  = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
    assign t1   = v_reg[7] + big1 + ch + sha_pkg::round_k(ctl.round_idx) + w;
    assign t2   = big0 + maj;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= sha_pkg::INIT_H[255 - 32 * i -: 32];
            end
        end
        else if (ctl.load_init)
        begin
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= sha_pkg::INIT_H[255 - 32 * i -: 32];
            end
        end
        else if (ctl.finish)
        begin
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= h_reg[i] + v_reg[i];
            end
        end
        else if (ctl.shift_out)
        begin
            for (int i = 0; i < 7; i++)
            begin
                h_reg[i] <= h_reg[i + 1];
            end
            h_reg[7] <= h_reg[0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            for (int i = 0; i < 8; i++)
            begin
                v_reg[i] <= h_reg[i];
            end
        end
        else if (ctl.round)
        begin
            v_reg[0] <= t1 + t2;
            v_reg[1] <= v_reg[0];
            v_reg[2] <= v_reg[1];
            v_reg[3] <= v_reg[2];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[5] <= v_reg[4];
            v_reg[6] <= v_reg[5];
            v_reg[7] <= v_reg[6];
        end
    end
endmodule

### hdl/sha256_byte_stream_hasher_unit.sv
// Channel | Payload type          | Handshake
// in      | sha_pkg::in_item_t    | in_valid / in_stall
// out     | sha_pkg::out_item_t   | out_valid / out_stall
// A byte that does not fill the block leaves it idle. A byte that fills it
// runs the start, the rounds and the chaining update.
// A final request also pads (up to 64 pad bytes per padded block, one or two
// blocks) and then shows eight digest words, one per accepted output cycle.
// Reset clears the sequencer and restores the initial chaining words.
// in_stall is high whenever the block is busy; out_stall only holds a word.
module sha256_byte_stream_hasher_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  sha_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output sha_pkg::out_item_t out_data
);
    typedef enum logic [2:0] {
        S_IDLE, S_PAD, S_START, S_ROUND, S_FIN, S_OUT
    } state_t;

    state_t      state_reg;
    logic [5:0]  cnt_reg;       // bytes in block, round index, pad position
    logic [63:0] bits_reg;
    logic        fin_reg;       // finishing the message
    logic        last_blk_reg;  // this compression ends the message
    logic [2:0]  widx_reg;
    logic        mark_done_reg; // the 0x80 marker has been loaded

    sha_pkg::core_ctl_t ctl;
    logic        load;
    logic [7:0]  load_byte;
    logic [7:0]  pad_byte;
    logic [63:0] len_shift;
    logic        mark_now;
    logic [31:0] w;
    logic [31:0] h0;
    logic        acc;

    assign acc      = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);

    // The 0x80 marker goes into the first padded slot.
    assign mark_now  = (state_reg == S_PAD) && !mark_done_reg;
    assign len_shift = bits_reg << {cnt_reg[2:0], 3'b000};

    // Padding byte at the current position: marker, length byte in the last block, or zero.
    always_comb
    begin
        if (mark_now)
            pad_byte = 8'h80;
        else if (last_blk_reg && cnt_reg >= 6'd56)
            pad_byte = len_shift[63:56];
        else
            pad_byte = 8'h00;
    end

    always_comb
    begin
        load      = 1'b0;
        load_byte = in_data.data_byte;
        if (state_reg == S_IDLE && acc && in_data.byte_present)
            load = 1'b1;
        else if (state_reg == S_PAD)
        begin
            load      = 1'b1;
            load_byte = pad_byte;
        end
        ctl.load_init = (state_reg == S_OUT) && !out_stall && (widx_reg == 3'd7);
        ctl.start     = (state_reg == S_START);
        ctl.round     = (state_reg == S_ROUND);
        ctl.round_idx = cnt_reg;
        ctl.finish    = (state_reg == S_FIN);
        ctl.shift_out = (state_reg == S_OUT) && !out_stall && (widx_reg != 3'd7);
    end

    sha_sched u_sched (
        .clk     (clk),
        .load    (load),
        .byte_in (load_byte),
        .step    (ctl.round),
        .w       (w)
    );

    sha_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .w     (w),
        .h0    (h0)
    );

    assign out_valid           = (state_reg == S_OUT);
    assign out_data.digest_word = h0;
    assign out_data.word_index = widx_reg;
    assign out_data.last_word  = (widx_reg == 3'd7);

    // The 0x80 marker is loaded at the first padding slot. last_blk_reg is set
    // when the marker leaves room for the length, or when the extra block starts.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            bits_reg      <= '0;
            fin_reg       <= 1'b0;
            last_blk_reg  <= 1'b0;
            widx_reg      <= '0;
            mark_done_reg <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (acc)
                    begin
                        if (in_data.byte_present)
                        begin
                            cnt_reg  <= cnt_reg + 6'd1;
                            bits_reg <= bits_reg + 64'd8;
                        end
                        fin_reg <= in_data.final_req;
                        if (in_data.byte_present && cnt_reg == 6'd63)
                        begin
                            state_reg    <= S_START;
                            last_blk_reg <= 1'b0;
                        end
                        else if (in_data.final_req)
                        begin
                            state_reg    <= S_PAD;
                            last_blk_reg <= 1'b0;
                        end
                    end
                end
                S_PAD:
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (mark_now)
                    begin
                        mark_done_reg <= 1'b1;
                        last_blk_reg  <= (cnt_reg < 6'd56);
                    end
                    if (cnt_reg == 6'd63)
                        state_reg <= S_START;
                end
                S_START:
                begin
                    cnt_reg   <= '0;
                    state_reg <= S_ROUND;
                end
                S_ROUND:
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd63)
                        state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    cnt_reg <= '0;
                    if (last_blk_reg)
                    begin
                        state_reg <= S_OUT;
                        widx_reg  <= '0;
                    end
                    else if (fin_reg)
                    begin
                        state_reg    <= S_PAD;
                        last_blk_reg <= mark_done_reg;
                    end
                    else
                        state_reg <= S_IDLE;
                end
                S_OUT:
                begin
                    if (!out_stall)
                    begin
                        widx_reg <= widx_reg + 3'd1;
                        if (widx_reg == 3'd7)
                        begin
                            state_reg     <= S_IDLE;
                            bits_reg      <= '0;
                            fin_reg       <= 1'b0;
                            last_blk_reg  <= 1'b0;
                            mark_done_reg <= 1'b0;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

### hdl/sha_checker.sv
`include "sha256_byte_stream_hasher_unit_defines.svh"
module sha_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input sha_pkg::out_item_t out_data
);
    `SHA_ASSERT(a_busy_out, !out_valid || in_stall, "input open while digest shown")
    `SHA_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled word changed")
    `SHA_ASSERT_NEXT(a_idx_step, out_valid && !out_stall && !out_data.last_word, out_valid && out_data.word_index == $past(out_data.word_index) + 3'd1, "word index skipped")
    `SHA_ASSERT_NEXT(a_end, out_valid && !out_stall && out_data.last_word, !out_valid, "extra digest word")
endmodule

bind sha256_byte_stream_hasher_unit sha_checker u_sha_checker (.*);
